// ----- rtl/xpg_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package xpg_pkg;

	localparam int DEF_MAX_COLUMNS = 64;
	localparam int DEF_MAX_WORDS   = 64;
	localparam int DEF_WORD_BITS   = 64;

	localparam int DATA_W      = 64;
	localparam int COL_W       = 6;
	localparam int WIDX_W      = 6;
	localparam int ROW_BITS_W  = 13;
	localparam int COL_COUNT_W = 7;
	localparam int ACC_W       = 13;
	localparam int DOT_W       = 14;
	localparam int POP_W       = 7;
	localparam int CFG_IDX_W   = 1;

	localparam logic [ROW_BITS_W-1:0]  ROW_BITS_RESET     = 13'd64;
	localparam logic [COL_COUNT_W-1:0] COLUMN_COUNT_RESET = 7'd1;

	localparam logic [CFG_IDX_W-1:0] REG_ROW_BITS     = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'd1;

	localparam logic ACT_LOAD   = 1'b0;
	localparam logic ACT_STREAM = 1'b1;

	localparam logic [DATA_W-1:0] POP_M1 = 64'h5555555555555555;
	localparam logic [DATA_W-1:0] POP_M2 = 64'h3333333333333333;
	localparam logic [DATA_W-1:0] POP_M4 = 64'h0F0F0F0F0F0F0F0F;

	// swar population count, result fits in seven bits
	function automatic logic [POP_W-1:0] count_ones(input logic [DATA_W-1:0] v);
		logic [DATA_W-1:0] t;
		t = v - ((v >> 1) & POP_M1);
		t = (t & POP_M2) + ((t >> 2) & POP_M2);
		t = (t + (t >> 4)) & POP_M4;
		t = t + (t >> 8);
		t = t + (t >> 16);
		t = t + (t >> 32);
		return t[POP_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ----- rtl/xnor_popcount_gemm.sv -----
`timescale 1ns / 1ps
`default_nettype none
// weight load: one word per cycle while in_ready is high, written straight into the weight memory
// activation word: in_ready stays low until it has passed through, one column
//   per cycle through the weight memory read port and the accumulator pipe
// row end: each accumulator is read and zeroed, the first column_count ones are sent
// reset: asynchronous, then a clearing pass over the accumulators
//   with in_ready low; config registers come up as row_bits 64, column_count 1
module xnor_popcount_gemm #(
	parameter int MAX_COLUMNS = xpg_pkg::DEF_MAX_COLUMNS,
	parameter int MAX_WORDS   = xpg_pkg::DEF_MAX_WORDS,
	parameter int WORD_BITS   = xpg_pkg::DEF_WORD_BITS
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,

	input  wire logic                               cfg_write_enable,
	input  wire logic [xpg_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [xpg_pkg::ROW_BITS_W-1:0]     cfg_data,

	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic                               action,
	input  wire logic [xpg_pkg::COL_W-1:0]          column,
	input  wire logic [xpg_pkg::WIDX_W-1:0]         word_index,
	input  wire logic [xpg_pkg::DATA_W-1:0]         data_word,
	input  wire logic                               row_end,

	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic [xpg_pkg::COL_W-1:0]               result_column,
	output logic signed [xpg_pkg::DOT_W-1:0]        dot_value,
	output logic                                    last_of_row
);

	localparam int DEPTH     = MAX_COLUMNS * MAX_WORDS;
	localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CIW       = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int ROW_LIMIT = MAX_WORDS * WORD_BITS;
	localparam logic [CIW-1:0] LAST_COL = CIW'(MAX_COLUMNS - 1);

	localparam int DW  = xpg_pkg::DATA_W;
	localparam int ACW = xpg_pkg::ACC_W;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ACC,
		ST_DRAIN,
		ST_EMIT_RD,
		ST_EMIT_WR
	} state_t;

	state_t state_q;

	logic [xpg_pkg::ROW_BITS_W-1:0]  row_bits_q;
	logic [xpg_pkg::COL_COUNT_W-1:0] column_count_q;

	logic [CIW-1:0]    col_q;
	logic [DW-1:0]     data_q;
	logic [DW-1:0]     mask_q;
	logic [xpg_pkg::WIDX_W-1:0] widx_q;
	logic              row_end_q;

	logic              v_s1, v_s2;
	logic [CIW-1:0]    col_s1, col_s2;
	logic [xpg_pkg::POP_W-1:0] pop_s2;

	// memories
	logic [DW-1:0]  weight_mem [DEPTH];
	logic [DW-1:0]  w_rdata_q;
	logic [ACW-1:0] acc_mem [MAX_COLUMNS];
	logic [ACW-1:0] a_rdata_q;

	logic           w_we, w_re;
	logic [AW-1:0]  w_waddr, w_raddr;
	logic           a_we, a_re;
	logic [CIW-1:0] a_waddr, a_raddr;
	logic [ACW-1:0] a_wdata;

	logic [ACW-1:0] k;
	logic [xpg_pkg::COL_COUNT_W-1:0] n_cols;
	logic           in_fire;
	logic           acc_en;
	logic [31:0]    word_start;
	logic [31:0]    remain;
	logic [DW-1:0]  mask_d;
	logic [xpg_pkg::POP_W-1:0] pop_d;
	logic [ACW:0]   sum_s2;
	logic [ACW-1:0] sat_s2;
	logic           emit_col;
	logic           slot_free;
	logic           emit_step;

	always_comb begin
		k = (32'(row_bits_q) > ROW_LIMIT) ? ACW'(ROW_LIMIT) : row_bits_q;
		n_cols = (32'(column_count_q) > MAX_COLUMNS) ?
			xpg_pkg::COL_COUNT_W'(MAX_COLUMNS) : column_count_q;
	end

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;

	// a word takes part only if it starts below the row length
	always_comb begin
		word_start = 32'(word_index) * WORD_BITS;
		remain     = 32'(k) - word_start;
		acc_en     = (32'(word_index) < MAX_WORDS) && (word_start < 32'(k));
		for (int j = 0; j < DW; j++) begin
			mask_d[j] = (j < WORD_BITS) && (32'(j) < remain);
		end
	end

	assign w_we    = in_fire && (action == xpg_pkg::ACT_LOAD) && (32'(column) < MAX_COLUMNS)
		&& (32'(word_index) < MAX_WORDS);
	assign w_waddr = AW'(32'(column) * MAX_WORDS + 32'(word_index));
	assign w_re    = (state_q == ST_ACC);
	assign w_raddr = AW'(32'(col_q) * MAX_WORDS + 32'(widx_q));

	assign pop_d = xpg_pkg::count_ones(~(data_q ^ w_rdata_q) & mask_q);

	always_comb begin
		sum_s2 = {1'b0, a_rdata_q} + (ACW + 1)'(pop_s2);
		sat_s2 = (sum_s2 > {1'b0, k}) ? k : sum_s2[ACW-1:0];
	end

	assign emit_col  = 32'(col_q) < 32'(n_cols);
	assign slot_free = !out_valid || out_ready;
	assign emit_step = (state_q == ST_EMIT_WR) && (!emit_col || slot_free);

	always_comb begin
		a_re    = v_s1 || (state_q == ST_EMIT_RD);
		a_raddr = v_s1 ? col_s1 : col_q;
		a_we    = 1'b0;
		a_waddr = col_q;
		a_wdata = '0;
		if (v_s2) begin
			a_we    = 1'b1;
			a_waddr = col_s2;
			a_wdata = sat_s2;
		end else if (state_q == ST_CLEAR || emit_step) begin
			a_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (w_we) begin
			weight_mem[w_waddr] <= data_word;
		end
		if (w_re) begin
			w_rdata_q <= weight_mem[w_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (a_we) begin
			acc_mem[a_waddr] <= a_wdata;
		end
		if (a_re) begin
			a_rdata_q <= acc_mem[a_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_bits_q     <= xpg_pkg::ROW_BITS_RESET;
			column_count_q <= xpg_pkg::COLUMN_COUNT_RESET;
		end else if (cfg_write_enable) begin
			unique case (cfg_index)
				xpg_pkg::REG_ROW_BITS:     row_bits_q <= cfg_data;
				xpg_pkg::REG_COLUMN_COUNT: column_count_q <= cfg_data[xpg_pkg::COL_COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			col_q     <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			// accumulate pipe: s1 counts matches, s2 updates the accumulator
			v_s1   <= (state_q == ST_ACC);
			col_s1 <= col_q;
			v_s2   <= v_s1;
			col_s2 <= col_s1;
			pop_s2 <= pop_d;

			if (out_valid && out_ready && !(emit_step && emit_col)) begin
				out_valid <= 1'b0;
			end

			unique case (state_q)
				ST_CLEAR: begin
					if (col_q == LAST_COL) begin
						col_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						col_q <= col_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (in_fire && action == xpg_pkg::ACT_STREAM) begin
						data_q    <= data_word;
						mask_q    <= mask_d;
						widx_q    <= word_index;
						row_end_q <= row_end;
						col_q     <= '0;
						if (acc_en) begin
							state_q <= ST_ACC;
						end else if (row_end) begin
							state_q <= ST_EMIT_RD;
						end
					end
				end
				ST_ACC: begin
					if (col_q == LAST_COL) begin
						col_q   <= '0;
						state_q <= ST_DRAIN;
					end else begin
						col_q <= col_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (!v_s1 && !v_s2) begin
						state_q <= row_end_q ? ST_EMIT_RD : ST_IDLE;
					end
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_WR;
				end
				ST_EMIT_WR: begin
					if (emit_step) begin
						if (emit_col) begin
							out_valid     <= 1'b1;
							result_column <= xpg_pkg::COL_W'(col_q);
							dot_value     <= {a_rdata_q, 1'b0} - {1'b0, k};
							last_of_row   <= (32'(col_q) + 32'd1 == 32'(n_cols));
						end
						if (col_q == LAST_COL) begin
							col_q   <= '0;
							state_q <= ST_IDLE;
						end else begin
							col_q   <= col_q + 1'b1;
							state_q <= ST_EMIT_RD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire
